/* hw/rtl/aes_ctr_pkg.sv */
// Shared constants and functions for the AES-128 counter-mode cipher.
// No dependencies; used by the top level and the round-key RAM users.
`default_nettype none

package aes_ctr_pkg;

  localparam int unsigned RkDepth = 22;
  localparam int unsigned RkAw    = 5;
  localparam int unsigned NumRounds = 10;

  // Configuration register indexes.
  localparam logic [2:0] RegKeyLow   = 3'd0;
  localparam logic [2:0] RegKeyHigh  = 3'd1;
  localparam logic [2:0] RegNonceLow = 3'd2;
  localparam logic [2:0] RegNonceHi  = 3'd3;
  localparam logic [2:0] RegInitCtr  = 3'd4;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // One full round: SubBytes, ShiftRows, optional MixColumns. Key added by caller.
  // Byte j of the state sits in bits 8*j+7:8*j.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[8*(4*c) +: 8];
        a1 = t[8*(4*c+1) +: 8];
        a2 = t[8*(4*c+2) +: 8];
        a3 = t[8*(4*c+3) +: 8];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[8*(4*c) +: 8]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
        t[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
        t[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    aes_round = t;
  endfunction

  // Next four key-schedule words from the previous four.
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] n;
    t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    key_next = n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/aes_ctr_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module aes_ctr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 22
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/aes128_ctr_stream_cipher.sv */
// Top level of the AES-128 counter-mode stream cipher.
// Depends on aes_ctr_pkg and aes_ctr_ram (two instances hold the round keys).
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata: data_low, data_high; tuser: byte_count, last
//  m_axis  | out | m_axis_tvalid/tready   | tdata: result_low, result_high; tuser: count, last
//  cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A block inside a message runs from acceptance to result in these steps: StLoad
// adds round key 0, StRound steps through the rounds fed by one key RAM read each,
// and in StWait the last round goes to the output register. The input is ready
// again in the cycle after that handoff. The first block of a message first runs
// key expansion in StKey, one round key written per cycle. Reset clears the
// registers only. A stalled result holds in the output register while the next
// block runs; that block waits before its final step.
`default_nettype none

module aes128_ctr_stream_cipher (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // data_low, data_high
  input  wire logic [7:0]   s_axis_tuser,   // byte_count[4:0], last_block[5], zero fill
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata,   // result_low, result_high
  output logic      [7:0]   m_axis_tuser,   // result_byte_count[4:0], result_last[5]
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i
);
  import aes_ctr_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StKey, StLoad, StRound, StWait
  } state_e;

  state_e       state_q;
  logic [127:0] key_q;
  logic [95:0]  nonce_q;
  logic [31:0]  init_ctr_q, ctr_q;
  logic         in_msg_q;
  logic [127:0] kexp_q, st_q, data_q;
  logic [3:0]   step_q;
  logic [4:0]   cnt_q;
  logic         last_q;
  logic [127:0] out_data_q;
  logic [7:0]   out_user_q;
  logic         out_valid_q;

  logic            we;
  logic [RkAw-1:0] waddr, raddr;
  logic [127:0]    wdata, rk;
  logic [127:0]    knext, rnd, ctr_blk, ks, res;
  logic            handoff;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  aes_ctr_ram #(.Width(64), .Depth(RkDepth)) u_rk_lo (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata[63:0]),
    .raddr_i(raddr), .rdata_o(rk[63:0])
  );
  aes_ctr_ram #(.Width(64), .Depth(RkDepth)) u_rk_hi (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata[127:64]),
    .raddr_i(raddr), .rdata_o(rk[127:64])
  );

  // Both RAMs share one address; entry r of each holds half of round key r.
  always_comb begin
    knext = key_next(kexp_q, RCON[step_q]);
    we    = 1'b0;
    waddr = '0;
    wdata = knext;
    raddr = '0;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid && !in_msg_q) begin
          we = 1'b1;
          wdata = key_q;
        end
      end
      StKey: begin
        we    = 1'b1;
        waddr = RkAw'(step_q + 4'd1);
      end
      StLoad:  raddr = RkAw'(1);
      StRound: begin
        if (step_q == 4'(NumRounds)) begin
          raddr = RkAw'(NumRounds);
        end else begin
          raddr = RkAw'(step_q + 4'd1);
        end
      end
      default: raddr = RkAw'(NumRounds);
    endcase
  end

  assign rnd = aes_round(st_q, step_q != 4'(NumRounds));
  assign ctr_blk = {ctr_q[7:0], ctr_q[15:8], ctr_q[23:16], ctr_q[31:24], nonce_q};
  assign ks = rnd ^ rk;
  assign handoff = (state_q == StWait) && (!out_valid_q || m_axis_tready);

  // Mask bytes beyond the valid count; counts above sixteen keep all bytes.
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      res[8*j +: 8] = (5'(j) < cnt_q) ? (ks[8*j +: 8] ^ data_q[8*j +: 8]) : 8'h00;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      nonce_q <= '0;
      init_ctr_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegKeyLow:   key_q[63:0]    <= cfg_data_i;
        RegKeyHigh:  key_q[127:64]  <= cfg_data_i;
        RegNonceLow: nonce_q[63:0]  <= cfg_data_i;
        RegNonceHi:  nonce_q[95:64] <= cfg_data_i[31:0];
        RegInitCtr:  init_ctr_q     <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer: key expansion for the first block of a message, then one round per cycle, then output handoff.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      in_msg_q <= 1'b0;
      ctr_q <= '0;
      step_q <= '0;
      out_valid_q <= 1'b0;
      kexp_q <= '0;
      st_q <= '0;
      data_q <= '0;
      cnt_q <= '0;
      last_q <= 1'b0;
      out_data_q <= '0;
      out_user_q <= '0;
    end else begin
      if (handoff) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            data_q <= s_axis_tdata;
            cnt_q  <= s_axis_tuser[4:0];
            last_q <= s_axis_tuser[5];
            step_q <= '0;
            if (!in_msg_q) begin
              kexp_q <= key_q;
              ctr_q <= init_ctr_q;
              in_msg_q <= 1'b1;
              state_q <= StKey;
            end else begin
              state_q <= StLoad;
            end
          end
        end
        StKey: begin
          kexp_q <= knext;
          if (step_q == 4'(NumRounds - 1)) begin
            step_q <= '0;
            state_q <= StLoad;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        StLoad: begin
          st_q <= ctr_blk ^ rk;
          step_q <= 4'd1;
          state_q <= StRound;
        end
        StRound: begin
          if (step_q == 4'(NumRounds)) begin
            state_q <= StWait;
          end else begin
            st_q <= ks;
            step_q <= step_q + 4'd1;
          end
        end
        StWait: begin
          if (handoff) begin
            out_data_q <= res;
            out_user_q <= {2'b00, last_q, cnt_q};
            ctr_q <= ctr_q + 32'd1;
            if (last_q) in_msg_q <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire
